@@ hdl/assert_macros.svh @@
// Assertion macros shared by the SPI master byte shifter RTL.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the synchronous reset is asserted.
`define SPM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/spm_pkg.sv @@
// Package for the SPI master byte shifter: payload types, phase enum, constants.
// No dependencies.
`timescale 1ns / 1ps

package spm_pkg;

    // Queue between front and back
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Configuration register indexes
    localparam logic [1:0] CFG_SPI_MODE  = 2'd0;
    localparam logic [1:0] CFG_HALF_PER  = 2'd1;
    localparam logic [1:0] CFG_GAP_TICKS = 2'd2;

    localparam logic [1:0]  RST_SPI_MODE  = 2'd0;
    localparam logic [15:0] RST_HALF_PER  = 16'd10;
    localparam logic [15:0] RST_GAP_TICKS = 16'd0;
    localparam logic [2:0]  TOP_BIT       = 3'd7;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2,
        PH_GAP    = 2'd3
    } t_phase;

    // One clock tick request
    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       miso_level;
    } t_tick;

    // One tick result
    typedef struct packed {
        logic       sck_level;
        logic       mosi_level;
        logic       busy_res;
        logic       rx_valid;
        logic [7:0] rx_byte;
    } t_res;

    // Configuration write bundle
    typedef struct packed {
        logic        we;
        logic [1:0]  idx;
        logic [15:0] data;
    } t_cfg_wr;

endpackage

@@ hdl/spm_stream_if.sv @@
// Valid/ready stream interface carrying one packed payload.
// No dependencies; payload type is set per instance.
`timescale 1ns / 1ps

interface spm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/spi_master_byte_shifter.sv @@
// Top level of the SPI master byte shifter: front queue plus back sequencer.
// Depends on spm_pkg, spm_stream_if, spm_front and spm_back.
//
//  channel   dir  payload                                           handshake
//  i_in      in   tx_valid, tx_byte[7:0], miso_level                valid/ready
//  o_out     out  sck_level, mosi_level, busy_res, rx_valid, rx_byte valid/ready
//  i_cfg_*   in   idx[1:0], data[15:0]                              write enable
//
// One tick request in, one result out; sustained rate is one tick per cycle while the output is not stalled.
// From accept to result a tick passes through a queue slot, then the result register.
// The back sequencer steps once per tick and advances only when the result
// register is free or being drained; a stalled output backs up the two-entry queue.
// Synchronous active-low reset clears the phase, counters, queue and config.
`timescale 1ns / 1ps

module spi_master_byte_shifter
    import spm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data,
    spm_stream_if.sink   i_in,
    spm_stream_if.source o_out
);

    t_cfg_wr cfg_wr;

    spm_stream_if #(.T(t_tick)) w_q ();

    assign cfg_wr.we   = i_cfg_we;
    assign cfg_wr.idx  = i_cfg_idx;
    assign cfg_wr.data = i_cfg_data;

    // Request queue
    spm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_q     (w_q.source)
    );

    // Phase sequencer and result stage
    spm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_wr),
        .i_q     (w_q.sink),
        .o_out   (o_out)
    );

endmodule

@@ hdl/spm_front.sv @@
// Front end: accepts tick requests into a short register queue.
// Depends on spm_pkg and spm_stream_if.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spm_front
    import spm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    spm_stream_if.sink   i_in,
    spm_stream_if.source o_q
);

    t_tick              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               push;
    logic               pop;

    // Handshakes on both sides
    assign i_in.ready = (r_count != Q_CNT_W'(Q_DEPTH));
    assign push       = i_in.valid && i_in.ready;
    assign o_q.valid  = (r_count != '0);
    assign o_q.data   = r_mem[r_rd_ptr];
    assign pop        = o_q.valid && o_q.ready;

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_in.data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `SPM_ASSERT(a_cnt_up, i_clk, i_rst_n, $past(i_rst_n) && push && !pop |=> r_count == $past(r_count) + 1'b1, "queue count did not grow on push")
    `SPM_ASSERT(a_cnt_range, i_clk, i_rst_n, r_count <= Q_CNT_W'(Q_DEPTH), "queue overfilled")
    `SPM_ASSERT(a_ptr_gap, i_clk, i_rst_n, (r_count == '0) |-> (r_wr_ptr == r_rd_ptr), "empty queue with pointers apart")

endmodule

@@ hdl/spm_back.sv @@
// Back end: SPI phase sequencer, config registers and registered result stage.
// Depends on spm_pkg and spm_stream_if.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spm_back
    import spm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg_wr      i_cfg,
    spm_stream_if.sink   i_q,
    spm_stream_if.source o_out
);

    // Configuration registers
    logic [1:0]  r_mode;
    logic [15:0] r_half;
    logic [15:0] r_gap;

    // Sequencer state
    t_phase      r_phase, n_phase;
    logic [7:0]  r_send, n_send;
    logic [7:0]  r_recv, n_recv;
    logic [2:0]  r_bit, n_bit;
    logic [15:0] r_tick, n_tick;
    logic        r_sck, n_sck;
    logic        r_mosi, n_mosi;
    logic        n_done;

    // Result stage
    logic        r_out_valid;
    t_res        r_out;

    logic        step;
    logic        cpol;
    logic        cpha;
    logic [15:0] tick_inc;
    logic [15:0] half_lim;
    t_tick       item;

    assign item     = i_q.data;
    assign cpol     = r_mode[1];
    assign cpha     = r_mode[0];
    assign tick_inc = r_tick + 16'd1;
    assign half_lim = (r_half == 16'd0) ? 16'd1 : r_half;

    // One tick advances whenever the result stage can take it
    assign i_q.ready = !r_out_valid || o_out.ready;
    assign step      = i_q.valid && i_q.ready;

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= RST_SPI_MODE;
            r_half <= RST_HALF_PER;
            r_gap  <= RST_GAP_TICKS;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                CFG_SPI_MODE:  r_mode <= i_cfg.data[1:0];
                CFG_HALF_PER:  r_half <= i_cfg.data;
                CFG_GAP_TICKS: r_gap  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_send  <= '0;
            r_recv  <= '0;
            r_bit   <= TOP_BIT;
            r_tick  <= '0;
            r_sck   <= 1'b0;
            r_mosi  <= 1'b0;
        end else if (step) begin
            r_phase <= n_phase;
            r_send  <= n_send;
            r_recv  <= n_recv;
            r_bit   <= n_bit;
            r_tick  <= n_tick;
            r_sck   <= n_sck;
            r_mosi  <= n_mosi;
        end
    end

    // Next state for one tick
    always_comb begin
        n_phase = r_phase;
        n_send  = r_send;
        n_recv  = r_recv;
        n_bit   = r_bit;
        n_tick  = r_tick;
        n_sck   = r_sck;
        n_mosi  = r_mosi;
        n_done  = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                n_sck = cpol;
                if (item.tx_valid) begin
                    n_send  = item.tx_byte;
                    n_recv  = '0;
                    n_bit   = TOP_BIT;
                    n_mosi  = item.tx_byte[TOP_BIT];
                    n_tick  = '0;
                    n_phase = PH_FIRST;
                end
            end
            PH_FIRST: begin
                n_tick = tick_inc;
                if (tick_inc >= half_lim) begin
                    n_sck = ~cpol;
                    if (!cpha) begin
                        n_recv = {r_recv[6:0], item.miso_level};
                    end
                    n_tick  = '0;
                    n_phase = PH_SECOND;
                end
            end
            PH_SECOND: begin
                n_tick = tick_inc;
                if (tick_inc >= half_lim) begin
                    n_sck = cpol;
                    if (cpha) begin
                        n_recv = {r_recv[6:0], item.miso_level};
                    end
                    n_tick = '0;
                    if (r_bit == 3'd0) begin
                        if (r_gap == 16'd0) begin
                            n_done  = 1'b1;
                            n_phase = PH_IDLE;
                        end else begin
                            n_phase = PH_GAP;
                        end
                    end else begin
                        n_bit   = r_bit - 3'd1;
                        n_mosi  = r_send[n_bit];
                        n_phase = PH_FIRST;
                    end
                end
            end
            PH_GAP: begin
                n_sck  = cpol;
                n_tick = tick_inc;
                if (tick_inc >= r_gap) begin
                    n_tick  = '0;
                    n_done  = 1'b1;
                    n_phase = PH_IDLE;
                end
            end
            default: ;
        endcase
    end

    // Result stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result stage payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out.sck_level  <= n_sck;
            r_out.mosi_level <= n_mosi;
            r_out.busy_res   <= (n_phase != PH_IDLE);
            r_out.rx_valid   <= n_done;
            r_out.rx_byte    <= n_done ? n_recv : 8'd0;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    `SPM_ASSERT(a_done_idle, i_clk, i_rst_n, r_out_valid && r_out.rx_valid |-> !r_out.busy_res, "result reported while busy")
    `SPM_ASSERT(a_rx_zero, i_clk, i_rst_n, r_out_valid && !r_out.rx_valid |-> r_out.rx_byte == 8'd0, "rx byte without rx valid")
    `SPM_ASSERT(a_hold, i_clk, i_rst_n, $past(i_rst_n) && !step |=> $stable(r_phase) && $stable(r_tick), "sequencer moved without a tick")

endmodule
